@@ src/tpt_pkg.sv @@
`timescale 1ns / 1ps

package tpt_pkg;

	localparam int PORT_W           = 16;
	localparam int CAM_KEY_W        = 15;
	localparam int LISTEN_SLOTS_DEF = 16;
	localparam int SESSIONS_DEF     = 1024;

	// first ephemeral port; everything below is a listen port
	localparam logic [PORT_W-1:0] EPHEMERAL_BASE = 16'h8000;

	typedef enum logic [1:0] {
		CMD_LISTEN  = 2'd0,
		CMD_CHECK   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_LISTEN = 2'd0,
		KIND_CHECK  = 2'd1,
		KIND_ALLOC  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic lookup;
		logic insert;
	} cam_req_t;

	typedef struct packed {
		logic hit;
		logic full;
	} cam_rsp_t;

endpackage

@@ src/tpt_index.sv @@
`timescale 1ns / 1ps

module tpt_index #(
	parameter int SESSIONS = tpt_pkg::SESSIONS_DEF,
	parameter int IDX_W    = $clog2(SESSIONS)
) (
	input  logic                      clk,
	input  logic [tpt_pkg::PORT_W-1:0] x,
	input  logic                      ld1,
	input  logic                      ld2,
	output logic [IDX_W-1:0]          idx
);

	localparam bit IS_POW2 = (SESSIONS & (SESSIONS - 1)) == 0;

	logic [IDX_W-1:0] idx_s2;

	generate
		if (IS_POW2) begin : g_pow2
			logic [IDX_W-1:0] low_s1;

			// power of two: the index is the low bits
			always_ff @(posedge clk) begin
				if (ld1) begin
					low_s1 <= x[IDX_W-1:0];
				end
				if (ld2) begin
					idx_s2 <= low_s1;
				end
			end
		end else begin : g_recip
			localparam int MUL_SH = tpt_pkg::PORT_W + IDX_W;
			localparam int REC_W  = 18;
			localparam int PROD_W = tpt_pkg::PORT_W + REC_W;
			localparam logic [REC_W-1:0] RECIP =
				REC_W'(((64'd1 << MUL_SH) + 64'(SESSIONS) - 64'd1) / 64'(SESSIONS));

			logic [PROD_W-1:0]          prod_s1;
			logic [tpt_pkg::PORT_W-1:0] x_s1;
			logic [tpt_pkg::PORT_W-1:0] quo;
			logic [31:0]                qs;
			logic [tpt_pkg::PORT_W-1:0] rem;

			// quotient by reciprocal multiply, then remainder with one correction
			always_comb begin
				quo = tpt_pkg::PORT_W'(prod_s1 >> MUL_SH);
				qs  = 32'(quo) * 32'(SESSIONS);
				rem = x_s1 - qs[tpt_pkg::PORT_W-1:0];
				if (rem >= tpt_pkg::PORT_W'(SESSIONS)) begin
					rem = rem - tpt_pkg::PORT_W'(SESSIONS);
				end
			end

			always_ff @(posedge clk) begin
				if (ld1) begin
					x_s1    <= x;
					prod_s1 <= PROD_W'(x) * PROD_W'(RECIP);
				end
				if (ld2) begin
					idx_s2 <= rem[IDX_W-1:0];
				end
			end
		end
	endgenerate

	assign idx = idx_s2;

endmodule

@@ src/tpt_cam.sv @@
`timescale 1ns / 1ps

module tpt_cam #(
	parameter int SLOTS  = tpt_pkg::LISTEN_SLOTS_DEF,
	parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tpt_pkg::CAM_KEY_W-1:0] key,
	input  tpt_pkg::cam_req_t             req,
	output tpt_pkg::cam_rsp_t             rsp
);

	logic [tpt_pkg::CAM_KEY_W-1:0] entry_q [SLOTS];
	logic [SLOTS-1:0]              valid_q;
	logic                          hit_q;
	logic                          full_q;
	logic [SLOT_W-1:0]             slot_q;

	logic              hit;
	logic              free_found;
	logic [SLOT_W-1:0] free_slot;

	// compare every slot; pick the lowest free one
	always_comb begin
		hit        = 1'b0;
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (valid_q[i] && (entry_q[i] == key)) begin
				hit = 1'b1;
			end
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.insert) begin
			valid_q[slot_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.lookup) begin
			hit_q  <= hit;
			full_q <= !free_found;
			slot_q <= free_slot;
		end
		if (req.insert) begin
			entry_q[slot_q] <= key;
		end
	end

	assign rsp.hit  = hit_q;
	assign rsp.full = full_q;

`ifndef SYNTHESIS
	a_insert_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		req.insert |-> !valid_q[slot_q] && !hit_q && !full_q)
		else $error("insert into a busy slot or on a hit");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req.insert |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
		else $error("insert did not add exactly one slot");

	a_no_lookup_insert: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.insert && req.lookup))
		else $error("lookup and insert in the same cycle");
`endif

endmodule

@@ src/tpt_bitmap.sv @@
`timescale 1ns / 1ps

module tpt_bitmap #(
	parameter int DEPTH = tpt_pkg::SESSIONS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/tcp_port_table.sv @@
`timescale 1ns / 1ps

// TCP port table: listen CAM for ports below 32768 plus an in-use bitmap
// for ephemeral ports 32768 + index, with a wrapping allocation cursor.
// Input channel (in_valid / in_stall): cmd and port. Listen and check give
// one reply item each, release gives none, a tick gives an allocated port
// item only when the entry under the cursor was free.
// Output channel (out_valid / out_stall): kind, ok, alloc_port, held in an
// output register that stays put while out_stall is high.
// One item is in flight at a time: accept, index, bitmap read, finish.
// The reply is loaded into the output register in the finish step. The
// bitmap read port and the index stage (reciprocal multiply when SESSIONS
// is not a power of two) are registered, hence the separate index and read
// steps.
// The finish step of an item that gives a reply waits while a reply is
// still held and out_stall is high; a new item is not taken until that step completes.
// After reset the bitmap is cleared one entry per cycle, every entry in turn,
// with in_stall high. The listen valid bits and the cursor clear at once.
module tcp_port_table #(
	parameter int LISTEN_SLOTS = tpt_pkg::LISTEN_SLOTS_DEF,
	parameter int SESSIONS     = tpt_pkg::SESSIONS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [tpt_pkg::PORT_W-1:0] port,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 kind,
	output logic                       ok,
	output logic [tpt_pkg::PORT_W-1:0] alloc_port
);

	localparam int IDX_W = $clog2(SESSIONS);

	tpt_pkg::state_t st_q, st_d;

	tpt_pkg::cmd_t              cmd_q;
	logic [tpt_pkg::PORT_W-1:0] x_q;
	logic [tpt_pkg::PORT_W-1:0] x_in;
	logic [IDX_W-1:0]           cursor_q;
	logic [IDX_W-1:0]           clr_cnt_q;
	logic [IDX_W-1:0]           idx;

	logic                       out_valid_q;
	tpt_pkg::kind_t             kind_q;
	logic                       ok_q;
	logic [tpt_pkg::PORT_W-1:0] alloc_port_q;

	tpt_pkg::cam_req_t cam_req;
	tpt_pkg::cam_rsp_t cam_rsp;

	logic             accept;
	logic             clr_last;
	logic             high;
	logic             rd_bit;
	logic             has_res;
	logic             res_ok;
	tpt_pkg::kind_t   res_kind;
	logic             res_alloc;
	logic             done_go;
	logic             done_fire;
	logic             load;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic             mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;

	assign accept = in_valid && !in_stall;

	// undo the byte swap for check items
	assign x_in = (tpt_pkg::cmd_t'(cmd) == tpt_pkg::CMD_CHECK) ?
		{port[7:0], port[15:8]} : port;

	assign high     = x_q[tpt_pkg::PORT_W-1];
	assign clr_last = clr_cnt_q == IDX_W'(SESSIONS - 1);

	// reply decision in the finish step
	always_comb begin
		has_res   = 1'b0;
		res_ok    = 1'b0;
		res_kind  = tpt_pkg::KIND_LISTEN;
		res_alloc = 1'b0;
		case (cmd_q)
			tpt_pkg::CMD_LISTEN: begin
				has_res = 1'b1;
				res_ok  = !high && (cam_rsp.hit || !cam_rsp.full);
			end
			tpt_pkg::CMD_CHECK: begin
				has_res  = 1'b1;
				res_kind = tpt_pkg::KIND_CHECK;
				res_ok   = high ? rd_bit : cam_rsp.hit;
			end
			tpt_pkg::CMD_RELEASE: begin
				has_res = 1'b0;
			end
			tpt_pkg::CMD_TICK: begin
				has_res   = !rd_bit;
				res_kind  = tpt_pkg::KIND_ALLOC;
				res_ok    = 1'b1;
				res_alloc = 1'b1;
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	assign done_go   = !has_res || !out_valid_q || !out_stall;
	assign done_fire = (st_q == tpt_pkg::ST_DONE) && done_go;
	assign load      = done_fire && has_res;

	// sequencer: next state and stall
	always_comb begin
		st_d     = st_q;
		in_stall = 1'b1;
		case (st_q)
			tpt_pkg::ST_CLEAR: begin
				if (clr_last) begin
					st_d = tpt_pkg::ST_IDLE;
				end
			end
			tpt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					st_d = tpt_pkg::ST_INDEX;
				end
			end
			tpt_pkg::ST_INDEX: begin
				st_d = tpt_pkg::ST_READ;
			end
			tpt_pkg::ST_READ: begin
				st_d = tpt_pkg::ST_DONE;
			end
			tpt_pkg::ST_DONE: begin
				if (done_go) begin
					st_d = tpt_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = tpt_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tpt_pkg::ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	// CAM: compare in the index step, insert when a listen of a new port below 32768 finishes with a free slot
	assign cam_req.lookup = st_q == tpt_pkg::ST_INDEX;
	assign cam_req.insert = done_fire && (cmd_q == tpt_pkg::CMD_LISTEN) && !high &&
		!cam_rsp.hit && !cam_rsp.full;

	// bitmap ports: clear sweep, release of an ephemeral port clears, free tick sets
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx;
		mem_wdata = 1'b0;
		if (st_q == tpt_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
		end else if (done_fire && (cmd_q == tpt_pkg::CMD_RELEASE) && high) begin
			mem_we = 1'b1;
		end else if (done_fire && (cmd_q == tpt_pkg::CMD_TICK) && !rd_bit) begin
			mem_we    = 1'b1;
			mem_waddr = cursor_q;
			mem_wdata = 1'b1;
		end
	end

	assign mem_re    = st_q == tpt_pkg::ST_READ;
	assign mem_raddr = (cmd_q == tpt_pkg::CMD_TICK) ? cursor_q : idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == tpt_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
			end
			// advance and wrap the cursor on every tick
			if (done_fire && (cmd_q == tpt_pkg::CMD_TICK)) begin
				cursor_q <= (cursor_q == IDX_W'(SESSIONS - 1)) ? '0 : cursor_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= tpt_pkg::cmd_t'(cmd);
			x_q   <= x_in;
		end
		if (load) begin
			kind_q       <= res_kind;
			ok_q         <= res_ok;
			alloc_port_q <= res_alloc ?
				(tpt_pkg::EPHEMERAL_BASE | tpt_pkg::PORT_W'(cursor_q)) : '0;
		end
	end

	tpt_index #(
		.SESSIONS (SESSIONS),
		.IDX_W    (IDX_W)
	) u_index (
		.clk (clk),
		.x   (x_in),
		.ld1 (accept),
		.ld2 (st_q == tpt_pkg::ST_INDEX),
		.idx (idx)
	);

	tpt_cam #(
		.SLOTS (LISTEN_SLOTS)
	) u_cam (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (x_q[tpt_pkg::CAM_KEY_W-1:0]),
		.req    (cam_req),
		.rsp    (cam_rsp)
	);

	tpt_bitmap #(
		.DEPTH (SESSIONS),
		.AW    (IDX_W)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_bit)
	);

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign ok         = ok_q;
	assign alloc_port = alloc_port_q;

`ifndef SYNTHESIS
	a_alloc_is_ephemeral: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tpt_pkg::KIND_ALLOC) |-> alloc_port[15] && ok)
		else $error("allocated port below the ephemeral range");

	a_reply_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != tpt_pkg::KIND_ALLOC) |-> alloc_port == '0)
		else $error("reply item carries a port");

	a_tick_moves_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire && (cmd_q == tpt_pkg::CMD_TICK) |=> cursor_q != $past(cursor_q))
		else $error("tick did not advance the cursor");

	a_no_load_outside_done: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (st_q == tpt_pkg::ST_DONE) && (!out_valid_q || !out_stall))
		else $error("reply loaded over a held item");
`endif

endmodule
